// ===== hdl/accel_fifo_triplet_deframer_macros.svh =====
// Assertion macros for the accelerometer FIFO triplet deframer checker.
`ifndef ACCEL_FIFO_TRIPLET_DEFRAMER_MACROS_SVH
`define ACCEL_FIFO_TRIPLET_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AFD_ASSERT_IMPLY(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("afd assertion failed");

// Next-cycle implication, disabled during reset.
`define AFD_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("afd assertion failed");

`endif

// ===== hdl/afd_pkg.sv =====
// Shared types for the accelerometer FIFO triplet deframer.
package afd_pkg;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_EMPTY  = 2'd1,
    KIND_NONE   = 2'd2
  } kind_e;

endpackage

// ===== hdl/accel_fifo_triplet_deframer.sv =====
// Top level: accelerometer FIFO triplet deframer, start/word beats in, triplet beats out.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------------------
//   in       | in_valid_i / in_ready_o    | op, request_count, fifo_entries, fifo_word
//   out      | out_valid_o / out_ready_i  | kind, accel_x/y/z, samples_read, last
//
// One input beat per cycle while in_ready_o is high; a result appears in the output
// register in the cycle after the beat that causes it. in_ready_o is low only while a
// result waits in the full output register and out_ready_i is low. Reset returns the
// phase machine to idle and empties the output register.
module accel_fifo_triplet_deframer #(
  parameter int SAMPLE_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [15:0]           request_count_i,
  input  logic [6:0]            fifo_entries_i,
  input  logic [23:0]           fifo_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output afd_pkg::kind_e        kind_o,
  output logic signed [19:0]    accel_x_o,
  output logic signed [19:0]    accel_y_o,
  output logic signed [19:0]    accel_z_o,
  output logic [5:0]            samples_read_o,
  output logic                  last_o
);
  import afd_pkg::*;

  localparam logic OP_START = 1'b0;
  localparam logic [14:0] DIV3_MUL = 15'd171;
  localparam int DIV3_SHIFT = 9;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_HUNT  = 4'b0010,
    PH_GOT_X = 4'b0100,
    PH_GOT_Y = 4'b1000
  } phase_e;

  function automatic logic [19:0] sample_of(logic [23:0] w);
    logic signed [SAMPLE_BITS-1:0] raw;
    logic signed [23:0]            ext;
    raw = w[23 -: SAMPLE_BITS];
    ext = 24'(raw);
    return ext[19:0];
  endfunction

  phase_e      phase_q, phase_d;
  logic [23:0] held_x_q, held_x_d;
  logic [23:0] held_y_q, held_y_d;
  logic [5:0]  remaining_q, remaining_d;
  logic [5:0]  delivered_q, delivered_d;

  logic               out_valid_q, out_valid_d;
  kind_e              kind_q, kind_d;
  logic signed [19:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [5:0]         count_q, count_d;
  logic               last_q, last_d;

  logic        in_fire;
  logic        res_valid;
  logic [14:0] div_prod;
  logic [5:0]  triplets;
  logic [5:0]  lim;
  logic        any_empty;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // entries / 3 by reciprocal, exact for 7-bit counts
  assign div_prod = 15'(fifo_entries_i) * DIV3_MUL;
  assign triplets = 6'(div_prod >> DIV3_SHIFT);
  assign lim = (request_count_i < 16'(triplets)) ? request_count_i[5:0] : triplets;
  assign any_empty = held_x_q[1] || held_y_q[1] || fifo_word_i[1];

  always_comb begin
    phase_d     = phase_q;
    held_x_d    = held_x_q;
    held_y_d    = held_y_q;
    remaining_d = remaining_q;
    delivered_d = delivered_q;
    res_valid   = 1'b0;
    kind_d      = KIND_SAMPLE;
    x_d         = '0;
    y_d         = '0;
    z_d         = '0;
    count_d     = delivered_q;
    last_d      = 1'b1;
    if (in_fire) begin
      if (op_i == OP_START) begin
        delivered_d = '0;
        held_x_d    = '0;
        held_y_d    = '0;
        if (lim == 6'd0) begin
          remaining_d = '0;
          phase_d     = PH_IDLE;
          res_valid   = 1'b1;
          kind_d      = KIND_NONE;
          count_d     = '0;
        end else begin
          remaining_d = lim;
          phase_d     = PH_HUNT;
        end
      end else begin
        case (phase_q)
          PH_HUNT: begin
            if (fifo_word_i[0]) begin
              held_x_d = fifo_word_i;
              phase_d  = PH_GOT_X;
            end
          end
          PH_GOT_X: begin
            held_y_d = fifo_word_i;
            phase_d  = PH_GOT_Y;
          end
          PH_GOT_Y: begin
            res_valid = 1'b1;
            if (any_empty) begin
              phase_d     = PH_IDLE;
              remaining_d = '0;
              kind_d      = KIND_EMPTY;
            end else begin
              delivered_d = delivered_q + 6'd1;
              remaining_d = remaining_q - 6'd1;
              phase_d     = (remaining_q == 6'd1) ? PH_IDLE : PH_HUNT;
              kind_d      = KIND_SAMPLE;
              x_d         = sample_of(held_x_q);
              y_d         = sample_of(held_y_q);
              z_d         = sample_of(fifo_word_i);
              count_d     = delivered_q + 6'd1;
              last_d      = (remaining_q == 6'd1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      held_x_q    <= '0;
      held_y_q    <= '0;
      remaining_q <= '0;
      delivered_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      held_x_q    <= held_x_d;
      held_y_q    <= held_y_d;
      remaining_q <= remaining_d;
      delivered_q <= delivered_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      kind_q  <= kind_d;
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      count_q <= count_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign accel_x_o      = x_q;
  assign accel_y_o      = y_q;
  assign accel_z_o      = z_q;
  assign samples_read_o = count_q;
  assign last_o         = last_q;

endmodule

// ===== hdl/afd_checker.sv =====
// Port-level checker for the accelerometer FIFO triplet deframer, with its bind.
`include "accel_fifo_triplet_deframer_macros.svh"

module afd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input afd_pkg::kind_e     kind_o,
  input logic signed [19:0] accel_x_o,
  input logic signed [19:0] accel_y_o,
  input logic signed [19:0] accel_z_o,
  input logic [5:0]         samples_read_o,
  input logic               last_o
);
  import afd_pkg::*;

  logic [68:0] out_beat;
  logic        out_stall;
  logic        ended;
  logic        none_beat;
  logic        no_data;

  assign out_beat  = {kind_o, accel_x_o, accel_y_o, accel_z_o, samples_read_o, last_o};
  assign out_stall = out_valid_o && !out_ready_i;
  assign ended     = out_valid_o && (kind_o != KIND_SAMPLE);
  assign none_beat = out_valid_o && (kind_o == KIND_NONE);
  assign no_data   = (accel_x_o == '0) && (accel_y_o == '0) && (accel_z_o == '0);

  `AFD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_beat))
  `AFD_ASSERT_IMPLY(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)
  `AFD_ASSERT_IMPLY(a_end_is_last, clk_i, rst_ni, ended, last_o)
  `AFD_ASSERT_IMPLY(a_end_no_data, clk_i, rst_ni, ended, no_data)
  `AFD_ASSERT_IMPLY(a_none_zero_count, clk_i, rst_ni, none_beat, samples_read_o == 6'd0)

endmodule

bind accel_fifo_triplet_deframer afd_checker u_afd_checker (.*);
